// ===== rtl/bmhpq_pkg.sv =====
package bmhpq_pkg;

	// Field widths of the request and response
	localparam int OP_W   = 3;
	localparam int KEY_W  = 32;
	localparam int IDX_W  = 7;
	localparam int STAT_W = 2;
	localparam int OCC_W  = 8;

	localparam int CAPACITY_DEF = 128;

	// Opcodes
	localparam logic [OP_W-1:0] OP_INSERT  = 3'd0;
	localparam logic [OP_W-1:0] OP_EXTRACT = 3'd1;
	localparam logic [OP_W-1:0] OP_PEEK    = 3'd2;
	localparam logic [OP_W-1:0] OP_CHANGE  = 3'd3;
	localparam logic [OP_W-1:0] OP_DELETE  = 3'd4;

	// Status codes
	localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
	localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
	localparam logic [STAT_W-1:0] ST_EMPTY = 2'd2;
	localparam logic [STAT_W-1:0] ST_RANGE = 2'd3;

	// Extreme keys
	localparam logic [KEY_W-1:0] KEY_MAX = 32'h7FFF_FFFF;
	localparam logic [KEY_W-1:0] KEY_MIN = 32'h8000_0000;

	typedef struct packed {
		logic [OP_W-1:0]         opcode;
		logic signed [KEY_W-1:0] key_value;
		logic [IDX_W-1:0]        entry_index;
	} req_t;

	typedef struct packed {
		logic signed [KEY_W-1:0] result_value;
		logic [STAT_W-1:0]       status;
		logic [OCC_W-1:0]        occupancy;
	} rsp_t;

endpackage

// ===== rtl/bmhpq_ram.sv =====
module bmhpq_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 128
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr_a,
	input  logic [$clog2(DEPTH)-1:0] raddr_b,
	output logic [WIDTH-1:0]         rdata_a,
	output logic [WIDTH-1:0]         rdata_b
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// One write port, two registered read ports
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_a <= mem_q[raddr_a];
		rdata_b <= mem_q[raddr_b];
	end

endmodule

// ===== rtl/binary_max_heap_priority_queue.sv =====
// Binary max-heap priority queue of signed 32-bit keys.
// Request channel (req_valid / req_stall / req_data): one request carries an
// opcode (insert, extract max, peek max, change key at index, delete at index),
// a key and an entry index. A request is taken when req_valid is high and
// req_stall is low; req_stall stays high while a request is being worked on.
// Response channel (rsp_valid / rsp_stall / rsp_data): exactly one response per
// request, carrying the extracted or peeked key, a status and the occupancy.
// A request is worked on by a small sequencer around one two-read, one-write
// key store and one compare stage. Peek, failed requests and unused opcodes
// need no sift. Each sift-up level reads the parent, then compares and moves;
// each sift-down level reads both children, then compares and moves. Delete
// does the most work: a sift-up to the root, then a sift-down from the root.
// Throughput: one request at a time; the next one is taken as soon as the
// previous response sits in the output register.
// Reset empties the heap at once (count cleared); no clearing pass is needed
// since only entries below the count are ever read.
// A stalled response holds in the output register; a finished request then
// waits in its final state until the register frees, and a new request may be
// taken meanwhile only once that response has been moved out.
module binary_max_heap_priority_queue #(
	parameter int CAPACITY = bmhpq_pkg::CAPACITY_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             req_valid,
	output logic             req_stall,
	input  bmhpq_pkg::req_t  req_data,
	output logic             rsp_valid,
	input  logic             rsp_stall,
	output bmhpq_pkg::rsp_t  rsp_data
);

	import bmhpq_pkg::*;

	// Position width, count width, child index width, index compare width
	localparam int IW   = $clog2(CAPACITY);
	localparam int CW   = $clog2(CAPACITY + 1);
	localparam int XW   = IW + 2;
	localparam int CMPW = (CW > IDX_W) ? CW : IDX_W;

	// Sequencer states
	localparam logic [3:0] S_IDLE     = 4'd0;
	localparam logic [3:0] S_UP_RD    = 4'd1;
	localparam logic [3:0] S_UP_CMP   = 4'd2;
	localparam logic [3:0] S_LAST_RD  = 4'd3;
	localparam logic [3:0] S_ROOT_GET = 4'd4;
	localparam logic [3:0] S_PEEK_GET = 4'd5;
	localparam logic [3:0] S_DN_RD    = 4'd6;
	localparam logic [3:0] S_DN_CMP   = 4'd7;
	localparam logic [3:0] S_DONE     = 4'd8;

	logic [3:0]              state_q;
	logic [OP_W-1:0]         op_q;
	logic [CW-1:0]           count_q;
	logic [IW-1:0]           pos_q;
	logic signed [KEY_W-1:0] val_q;     // key being sifted; its slot is the hole at pos_q
	logic [KEY_W-1:0]        res_q;
	logic [STAT_W-1:0]       stat_q;
	rsp_t                    rsp_q;
	logic                    rsp_valid_q;

	// Key store ports
	logic                    ram_we;
	logic [IW-1:0]           ram_waddr;
	logic [KEY_W-1:0]        ram_wdata;
	logic [IW-1:0]           ram_raddr_a;
	logic [IW-1:0]           ram_raddr_b;
	logic [KEY_W-1:0]        ram_rdata_a;
	logic [KEY_W-1:0]        ram_rdata_b;

	// Index arithmetic and compare results
	logic [IW-1:0]           par_idx;
	logic [IW-1:0]           last_idx;
	logic [XW-1:0]           lc_x;
	logic [XW-1:0]           rc_x;
	logic                    lc_ok;
	logic                    rc_ok;
	logic                    v_gt_a;
	logic                    a_gt_v;
	logic                    b_gt_v;
	logic                    b_gt_a;
	logic                    l_win;
	logic                    pick_l;
	logic                    pick_r;
	logic                    up_end;
	logic                    req_take;
	logic                    idx_bad;
	logic                    rsp_free;

	bmhpq_ram #(
		.WIDTH (KEY_W),
		.DEPTH (CAPACITY)
	) u_store (
		.clk     (clk),
		.we      (ram_we),
		.waddr   (ram_waddr),
		.wdata   (ram_wdata),
		.raddr_a (ram_raddr_a),
		.raddr_b (ram_raddr_b),
		.rdata_a (ram_rdata_a),
		.rdata_b (ram_rdata_b)
	);

	assign req_stall = (state_q != S_IDLE);
	assign req_take  = req_valid && !req_stall;
	assign rsp_free  = !rsp_valid_q || !rsp_stall;

	// Parent (i - 1) / 2, children 2i + 1 and 2i + 2
	assign par_idx  = (pos_q - 1'b1) >> 1;
	assign last_idx = IW'(count_q - 1'b1);
	assign lc_x     = {1'b0, pos_q, 1'b1};
	assign rc_x     = lc_x + XW'(1);
	assign lc_ok    = lc_x < XW'(count_q);
	assign rc_ok    = rc_x < XW'(count_q);

	// Compare stage: held key against the two read ports, and the ports against each other
	assign v_gt_a = val_q > $signed(ram_rdata_a);
	assign a_gt_v = $signed(ram_rdata_a) > val_q;
	assign b_gt_v = $signed(ram_rdata_b) > val_q;
	assign b_gt_a = $signed(ram_rdata_b) > $signed(ram_rdata_a);

	// Left wins over the held key; right must beat whichever of the two is best
	assign l_win  = lc_ok && a_gt_v;
	assign pick_r = rc_ok && (l_win ? b_gt_a : b_gt_v);
	assign pick_l = l_win && !pick_r;

	// Sift-up stops at the root or when the parent is not smaller
	assign up_end = ((state_q == S_UP_RD) && (pos_q == '0)) ||
	                ((state_q == S_UP_CMP) && !v_gt_a);

	assign idx_bad = CMPW'(req_data.entry_index) >= CMPW'(count_q);

	// Key store control
	always_comb begin
		ram_we      = 1'b0;
		ram_waddr   = pos_q;
		ram_wdata   = val_q;
		ram_raddr_a = '0;
		ram_raddr_b = last_idx;
		unique case (state_q)
			S_UP_RD: begin
				ram_raddr_a = par_idx;
			end
			S_UP_CMP: begin
				// Pull the parent down into the hole
				if (v_gt_a) begin
					ram_we    = 1'b1;
					ram_wdata = ram_rdata_a;
				end
			end
			S_LAST_RD: begin
				// Count already excludes the dropped key, so it names the last slot
				ram_raddr_b = IW'(count_q);
			end
			S_DN_RD: begin
				ram_raddr_a = lc_x[IW-1:0];
				ram_raddr_b = rc_x[IW-1:0];
			end
			S_DN_CMP: begin
				// Lift the larger child into the hole, or settle the key
				ram_we = 1'b1;
				if (pick_r) begin
					ram_wdata = ram_rdata_b;
				end else if (pick_l) begin
					ram_wdata = ram_rdata_a;
				end
			end
			default: begin
			end
		endcase
		// Settle the key where sift-up ends, unless change-key goes on to sift down
		if (up_end && (op_q != OP_CHANGE)) begin
			ram_we    = 1'b1;
			ram_wdata = val_q;
		end
	end

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			op_q    <= OP_INSERT;
			count_q <= '0;
			pos_q   <= '0;
			val_q   <= '0;
			res_q   <= '0;
			stat_q  <= ST_OK;
		end else begin
			unique case (state_q) inside
				S_IDLE: begin
					if (req_take) begin
						op_q   <= req_data.opcode;
						res_q  <= '0;
						stat_q <= ST_OK;
						unique case (req_data.opcode)
							OP_INSERT: begin
								if (count_q == CW'(CAPACITY)) begin
									stat_q  <= ST_FULL;
									state_q <= S_DONE;
								end else begin
									val_q   <= req_data.key_value;
									pos_q   <= IW'(count_q);
									count_q <= count_q + 1'b1;
									state_q <= S_UP_RD;
								end
							end
							OP_EXTRACT: begin
								// Root and last entry are read this cycle
								if (count_q == '0) begin
									stat_q  <= ST_EMPTY;
									state_q <= S_DONE;
								end else begin
									count_q <= count_q - 1'b1;
									state_q <= S_ROOT_GET;
								end
							end
							OP_PEEK: begin
								if (count_q == '0) begin
									stat_q  <= ST_EMPTY;
									res_q   <= KEY_MIN;
									state_q <= S_DONE;
								end else begin
									state_q <= S_PEEK_GET;
								end
							end
							OP_CHANGE: begin
								if (idx_bad) begin
									stat_q  <= ST_RANGE;
									state_q <= S_DONE;
								end else begin
									val_q   <= req_data.key_value;
									pos_q   <= IW'(req_data.entry_index);
									state_q <= S_UP_RD;
								end
							end
							OP_DELETE: begin
								// Raise the entry to the top key, lift it, then drop the root
								if (idx_bad) begin
									stat_q  <= ST_RANGE;
									state_q <= S_DONE;
								end else begin
									val_q   <= KEY_MAX;
									pos_q   <= IW'(req_data.entry_index);
									state_q <= S_UP_RD;
								end
							end
							default: begin
								state_q <= S_DONE;
							end
						endcase
					end
				end
				S_UP_RD, S_UP_CMP: begin
					if (!up_end) begin
						if (state_q == S_UP_RD) begin
							state_q <= S_UP_CMP;
						end else begin
							pos_q   <= par_idx;
							state_q <= S_UP_RD;
						end
					end else if (op_q == OP_CHANGE) begin
						state_q <= S_DN_RD;
					end else if (op_q == OP_DELETE) begin
						count_q <= count_q - 1'b1;
						state_q <= (count_q == CW'(1)) ? S_DONE : S_LAST_RD;
					end else begin
						state_q <= S_DONE;
					end
				end
				S_LAST_RD: begin
					state_q <= S_ROOT_GET;
				end
				S_ROOT_GET: begin
					if (op_q == OP_EXTRACT) begin
						res_q <= ram_rdata_a;
					end
					if (count_q == '0) begin
						state_q <= S_DONE;
					end else begin
						// Move the last entry to the root and sift it down
						val_q   <= ram_rdata_b;
						pos_q   <= '0;
						state_q <= S_DN_RD;
					end
				end
				S_PEEK_GET: begin
					res_q   <= ram_rdata_a;
					state_q <= S_DONE;
				end
				S_DN_RD: begin
					state_q <= S_DN_CMP;
				end
				S_DN_CMP: begin
					if (pick_r) begin
						pos_q   <= rc_x[IW-1:0];
						state_q <= S_DN_RD;
					end else if (pick_l) begin
						pos_q   <= lc_x[IW-1:0];
						state_q <= S_DN_RD;
					end else begin
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (rsp_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Output register: load on completion, drop once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if ((state_q == S_DONE) && rsp_free) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_valid_q && !rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == S_DONE) && rsp_free) begin
			rsp_q.result_value <= res_q;
			rsp_q.status       <= stat_q;
			rsp_q.occupancy    <= OCC_W'(count_q);
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp_data  = rsp_q;

endmodule
